/* hw/rtl/llad_pkg.sv */
// constants and tables for the logistic loss and derivatives pipeline
// used by llad_div and logistic_loss_and_derivatives_core; no dependencies
package llad_pkg;

    // port widths
    localparam int MARGIN_W = 24;
    localparam int LOSS_W   = 24;
    localparam int SLOPE_W  = 17;
    localparam int CURV_W   = 15;

    // internal widths of exp(-|z|) and the divider
    localparam int E_W       = 33;
    localparam int DEN_W     = 34;
    localparam int DIV_STEPS = 32;

    localparam logic [32:0] ONE33    = 33'h1_0000_0000;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    // floor(2^42 / ln2_q32), estimate of k = a / ln2 from a[36:24]
    localparam logic [10:0] K_RECIP  = 11'd1477;
    localparam logic [63:0] EXP_CUT  = 64'd98784247808;

    localparam logic [LOSS_W-1:0]  LOSS_MAX      = 24'hFFFFFF;
    localparam logic [32:0]        SLOPE_MAG_MAX = 33'd65536;
    localparam logic [62:0]        CURV_MAX      = 63'd16384;

    // exp(-r) horner steps, divisor n from 12 down to 1
    localparam int HORN_STEPS = 12;
    localparam logic [3:0] HORN_DIV [HORN_STEPS] = '{
        4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
    };
    // floor(2^32 / n) for the same order
    localparam logic [32:0] HORN_RECIP [HORN_STEPS] = '{
        33'd357913941, 33'd390451572, 33'd429496729, 33'd477218588,
        33'd536870912, 33'd613566756, 33'd715827882, 33'd858993459,
        33'd1073741824, 33'd1431655765, 33'd2147483648, 33'd4294967296
    };

    // atanh series steps, floor(2^32 / (2n+1)) for n from 11 down to 0
    localparam int SER_STEPS = 12;
    localparam logic [33:0] SER_INIT = 34'd171798691;
    localparam logic [33:0] SER_CONST [SER_STEPS] = '{
        34'd186737708, 34'd204522252, 34'd226050910, 34'd252645135,
        34'd286331153, 34'd330382099, 34'd390451572, 34'd477218588,
        34'd613566756, 34'd858993459, 34'd1431655765, 34'd4294967296
    };

endpackage

/* hw/rtl/llad_div.sv */
// pipelined restoring divider, one quotient bit per stage
// computes floor(num * 2^DIV_STEPS / den) for num < den; uses llad_pkg
module llad_div
    import llad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [E_W-1:0]       i_num,
    input  logic [DEN_W-1:0]     i_den,
    output logic [DIV_STEPS-1:0] o_quo
);

    logic [DEN_W-1:0]     r_rem [DIV_STEPS];
    logic [DEN_W-1:0]     r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS];

    logic [DEN_W-1:0]     w_rem_in [DIV_STEPS];
    logic [DEN_W-1:0]     w_den_in [DIV_STEPS];
    logic [DIV_STEPS-1:0] w_quo_in [DIV_STEPS];
    logic [DEN_W:0]       w_sh     [DIV_STEPS];
    logic [DEN_W:0]       w_dif    [DIV_STEPS];
    logic                 w_ge     [DIV_STEPS];

    // stage inputs: first from the ports, the rest from the previous stage
    always_comb begin
        w_rem_in[0] = DEN_W'(i_num);
        w_den_in[0] = i_den;
        w_quo_in[0] = '0;
        for (int i = 1; i < DIV_STEPS; i++) begin
            w_rem_in[i] = r_rem[i-1];
            w_den_in[i] = r_den[i-1];
            w_quo_in[i] = r_quo[i-1];
        end
    end

    // shift, compare and subtract per stage
    always_comb begin
        for (int i = 0; i < DIV_STEPS; i++) begin
            w_sh[i]  = {w_rem_in[i], 1'b0};
            w_ge[i]  = (w_sh[i] >= {1'b0, w_den_in[i]});
            w_dif[i] = w_sh[i] - {1'b0, w_den_in[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                r_rem[i] <= w_ge[i] ? w_dif[i][DEN_W-1:0] : w_sh[i][DEN_W-1:0];
                r_den[i] <= w_den_in[i];
                r_quo[i] <= {w_quo_in[i][DIV_STEPS-2:0], w_ge[i]};
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

/* hw/rtl/logistic_loss_and_derivatives_core.sv */
// logistic loss, slope and curvature of a fixed-point margin, fully pipelined
// depends on llad_pkg and llad_div
//
// Input channel: i_valid / o_ready carries one margin z per beat (two's
// complement, FRAC_BITS fraction bits). Output channel: o_valid / i_ready
// carries loss log(1+exp(-z)), slope -1/(1+exp(z)) and curvature
// exp(z)/(1+exp(z))^2 together in one beat, all saturated at field limits.
// One beat enters per cycle unless the output stalls. The depth is set by the
// 12-step exp horner chain (3 stages per step), the 32-stage dividers for the
// atanh argument and the sigmoid, and the 12-step atanh series (2 stages per
// step).
// Valid bits travel with the data. When the output holds a beat that is
// not taken, the whole pipeline holds and o_ready drops; nothing is lost
// or repeated. Reset clears the valid bits only; the block keeps no other
// state.
module logistic_loss_and_derivatives_core
    import llad_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [MARGIN_W-1:0] i_margin,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [LOSS_W-1:0]          o_loss_value,
    output logic signed [SLOPE_W-1:0]  o_slope,
    output logic [CURV_W-1:0]          o_curvature
);

    localparam int A_W      = MARGIN_W + 32 - FRAC_BITS;
    localparam int LS_W     = ((A_W > 35) ? A_W : 35) + 1;
    localparam int HL       = 3 * HORN_STEPS + 1;
    localparam int SL       = 2 * SER_STEPS + 1;
    localparam int ST_E     = 4 + 3 * HORN_STEPS + 1;
    localparam int ST_S2    = ST_E + DIV_STEPS + 1;
    localparam int ST_G2    = ST_S2 + 1;
    localparam int ST_SUM   = ST_S2 + 2 * SER_STEPS + 2;
    localparam int LAT      = ST_SUM + 1;
    localparam int CTX_LEN  = ST_SUM - 1;
    localparam int G_LEN    = LAT - ST_G2 + 1;
    localparam int SH_LOSS  = 32 - FRAC_BITS;
    localparam int SH_SLOPE = 31 - FRAC_BITS;
    localparam int SH_CURV  = 62 - FRAC_BITS;

    logic w_en;
    logic [LAT-1:0] r_vld;

    // the whole pipeline moves unless the output beat is stalled
    assign w_en    = ~r_vld[LAT-1] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // sign and magnitude of the margin, moved to 32 fraction bits
    logic                w_neg;
    logic [MARGIN_W-1:0] w_mag;
    logic                r_ctx_neg [CTX_LEN];
    logic [A_W-1:0]      r_ctx_a   [CTX_LEN];

    assign w_neg = i_margin[MARGIN_W-1];
    assign w_mag = w_neg ? (MARGIN_W'(0) - MARGIN_W'(i_margin)) : MARGIN_W'(i_margin);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx_neg[0] <= w_neg;
            r_ctx_a[0]   <= A_W'(w_mag) << SH_LOSS;
            for (int i = 1; i < CTX_LEN; i++) begin
                r_ctx_neg[i] <= r_ctx_neg[i-1];
                r_ctx_a[i]   <= r_ctx_a[i-1];
            end
        end
    end

    // range reduction a = k*ln2 + r: estimate k, then one correction
    logic [63:0] w_a64;
    logic        w_cut;
    logic [36:0] w_ac;
    logic [23:0] w_kp;
    logic [37:0] w_kl;
    logic        r2_cut;
    logic [36:0] r2_ac;
    logic [5:0]  r2_k0;
    logic        r3_cut;
    logic [32:0] r3_rest;
    logic [5:0]  r3_k0;
    logic        w_kfix;

    assign w_a64  = 64'(r_ctx_a[0]);
    assign w_cut  = (w_a64 >= EXP_CUT);
    assign w_ac   = w_cut ? 37'd0 : w_a64[36:0];
    assign w_kp   = 24'(w_ac[36:24]) * 24'(K_RECIP);
    assign w_kl   = 38'(r2_k0) * 38'(LN2_Q32);
    assign w_kfix = (r3_rest >= 33'(LN2_Q32));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cut  <= w_cut;
            r2_ac   <= w_ac;
            r2_k0   <= w_kp[23:18];
            r3_cut  <= r2_cut;
            r3_rest <= 33'(r2_ac - 37'(w_kl));
            r3_k0   <= r2_k0;
        end
    end

    // exp(-r) horner chain: multiply, reciprocal multiply, fix and subtract
    logic [31:0] r_hr   [HL];
    logic [5:0]  r_hk   [HL];
    logic        r_hcut [HL];
    logic [31:0] r_ht   [HORN_STEPS];
    logic [31:0] r_ht2  [HORN_STEPS];
    logic [31:0] r_hq0  [HORN_STEPS];
    logic [32:0] r_hp   [HORN_STEPS];
    logic [32:0] w_hp_in [HORN_STEPS];
    logic [64:0] w_hm    [HORN_STEPS];
    logic [64:0] w_hy    [HORN_STEPS];
    logic [35:0] w_hrem  [HORN_STEPS];
    logic [31:0] w_hq    [HORN_STEPS];

    always_comb begin
        w_hp_in[0] = ONE33;
        for (int i = 1; i < HORN_STEPS; i++) begin
            w_hp_in[i] = r_hp[i-1];
        end
        for (int i = 0; i < HORN_STEPS; i++) begin
            w_hm[i]   = 65'(r_hr[3*i]) * 65'(w_hp_in[i]);
            w_hy[i]   = 65'(r_ht[i]) * 65'(HORN_RECIP[i]);
            w_hrem[i] = 36'(r_ht2[i]) - 36'(r_hq0[i]) * 36'(HORN_DIV[i]);
            w_hq[i]   = (w_hrem[i] >= 36'(HORN_DIV[i])) ? r_hq0[i] + 32'd1 : r_hq0[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hr[0]   <= w_kfix ? 32'(r3_rest - 33'(LN2_Q32)) : r3_rest[31:0];
            r_hk[0]   <= w_kfix ? r3_k0 + 6'd1 : r3_k0;
            r_hcut[0] <= r3_cut;
            for (int i = 1; i < HL; i++) begin
                r_hr[i]   <= r_hr[i-1];
                r_hk[i]   <= r_hk[i-1];
                r_hcut[i] <= r_hcut[i-1];
            end
            for (int i = 0; i < HORN_STEPS; i++) begin
                r_ht[i]  <= w_hm[i][63:32];
                r_hq0[i] <= w_hy[i][63:32];
                r_ht2[i] <= r_ht[i];
                r_hp[i]  <= ONE33 - 33'(w_hq[i]);
            end
        end
    end

    // e = exp(-|z|) in q0.32
    logic [E_W-1:0] r_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e <= r_hcut[HL-1] ? '0 : (r_hp[HORN_STEPS-1] >> r_hk[HL-1]);
        end
    end

    // s = e/(2+e) and 2*g = e/(1+e), both scaled by 2^32
    logic [DIV_STEPS-1:0] w_quo_s;
    logic [DIV_STEPS-1:0] w_quo_g;

    llad_div u_div_s (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_e),
        .i_den ({1'b1, 33'd0} + DEN_W'(r_e)),
        .o_quo (w_quo_s)
    );

    llad_div u_div_g (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_e),
        .i_den (DEN_W'(ONE33) + DEN_W'(r_e)),
        .o_quo (w_quo_g)
    );

    // sigmoid path: g, h = 1/2 - g, their product and rounding
    logic [30:0] w_g;
    logic [31:0] w_h;
    logic [63:0] w_s2p;
    logic [62:0] r_gprod;
    logic [31:0] r_smag_raw;
    logic [32:0] w_smag;
    logic [62:0] w_curv;
    logic [SLOPE_W-1:0] w_smag_sat;
    logic [SLOPE_W-1:0] r_gd_slope [G_LEN];
    logic [CURV_W-1:0]  r_gd_curv  [G_LEN];

    assign w_g    = w_quo_g[31:1];
    assign w_h    = 32'h8000_0000 - 32'(w_g);
    assign w_s2p  = 64'(w_quo_s) * 64'(w_quo_s);
    assign w_smag = (33'(r_smag_raw) + (33'd1 << (SH_SLOPE - 1))) >> SH_SLOPE;
    assign w_curv = (r_gprod + (63'd1 << (SH_CURV - 1))) >> SH_CURV;
    assign w_smag_sat = (w_smag > SLOPE_MAG_MAX) ? SLOPE_W'(SLOPE_MAG_MAX)
                                                 : SLOPE_W'(w_smag);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gprod    <= 63'(w_g) * 63'(w_h);
            r_smag_raw <= r_ctx_neg[ST_S2-2] ? w_h : 32'(w_g);
            r_gd_slope[0] <= SLOPE_W'(0) - w_smag_sat;
            r_gd_curv[0]  <= (w_curv > CURV_MAX) ? CURV_W'(CURV_MAX) : CURV_W'(w_curv);
            for (int i = 1; i < G_LEN; i++) begin
                r_gd_slope[i] <= r_gd_slope[i-1];
                r_gd_curv[i]  <= r_gd_curv[i-1];
            end
        end
    end

    // log(1+e) = 2*s*atanh series in s^2, horner with truncation
    logic [31:0] r_ss  [SL];
    logic [31:0] r_ss2 [SL];
    logic [33:0] r_sm  [SER_STEPS];
    logic [33:0] r_st  [SER_STEPS];
    logic [33:0] w_st_in [SER_STEPS];
    logic [65:0] w_smul  [SER_STEPS];

    always_comb begin
        w_st_in[0] = SER_INIT;
        for (int j = 1; j < SER_STEPS; j++) begin
            w_st_in[j] = r_st[j-1];
        end
        for (int j = 0; j < SER_STEPS; j++) begin
            w_smul[j] = 66'(r_ss2[2*j]) * 66'(w_st_in[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ss[0]  <= w_quo_s;
            r_ss2[0] <= w_s2p[63:32];
            for (int i = 1; i < SL; i++) begin
                r_ss[i]  <= r_ss[i-1];
                r_ss2[i] <= r_ss2[i-1];
            end
            for (int j = 0; j < SER_STEPS; j++) begin
                r_sm[j] <= w_smul[j][65:32];
                r_st[j] <= SER_CONST[j] + r_sm[j];
            end
        end
    end

    // loss: 2*s*t, add |z| for negative margins, round and saturate
    logic [65:0]     w_lmul;
    logic [34:0]     r_lsum;
    logic [LS_W-1:0] r_lfull;
    logic [LS_W:0]   w_lrnd;
    logic [LOSS_W-1:0] r_loss;

    assign w_lmul = 66'(r_ss[SL-1]) * 66'(r_st[SER_STEPS-1]);
    assign w_lrnd = ((LS_W+1)'(r_lfull) + ((LS_W+1)'(1) << (SH_LOSS - 1))) >> SH_LOSS;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lsum  <= w_lmul[65:31];
            r_lfull <= LS_W'(r_lsum)
                     + (r_ctx_neg[CTX_LEN-1] ? LS_W'(r_ctx_a[CTX_LEN-1]) : LS_W'(0));
            r_loss  <= (w_lrnd > (LS_W+1)'(LOSS_MAX)) ? LOSS_MAX : LOSS_W'(w_lrnd);
        end
    end

    assign o_loss_value = r_loss;
    assign o_slope      = r_gd_slope[G_LEN-1];
    assign o_curvature  = r_gd_curv[G_LEN-1];

endmodule

/* bench/llad_checker.sv */
// scoreboard for the logistic loss core: predicts loss, slope and curvature per margin beat
// and compares output beats in order; depends on llad_pkg
`timescale 1ns / 1ps
module llad_checker
    import llad_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_o_ready,
    input  logic signed [MARGIN_W-1:0] i_margin,
    input  logic                       i_o_valid,
    input  logic                       i_ready,
    input  logic [LOSS_W-1:0]          i_loss_value,
    input  logic signed [SLOPE_W-1:0]  i_slope,
    input  logic [CURV_W-1:0]          i_curvature,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic [LOSS_W-1:0]  loss;
        logic [SLOPE_W-1:0] slope;
        logic [CURV_W-1:0]  curv;
    } terms_t;

    terms_t expected_terms[$];

    // exp(-a), a in Q.32, result Q0.32
    function automatic longint unsigned exp_neg(input longint unsigned a);
        longint unsigned k, r, p;
        if (a >= 64'd98784247808) begin
            return 0;
        end
        k = a / 64'd2977044472;
        r = a - k * 64'd2977044472;
        p = 64'd1 << 32;
        for (int n = 12; n >= 1; n--) begin
            p = (64'd1 << 32) - ((r * p) >> 32) / longint'(n);
        end
        return p >> k;
    endfunction

    // log(1+x) via atanh series, Q.32
    function automatic longint unsigned log_one_plus(input longint unsigned x);
        longint unsigned den, num, q, rem, s, s2, t;
        den = (64'd2 << 32) + x;
        num = x << 31;
        q   = num / den;
        rem = num % den;
        s   = 2 * q + (2 * rem) / den;
        s2  = (s * s) >> 32;
        t   = (64'd1 << 32) / 25;
        for (int n = 11; n >= 0; n--) begin
            t = (64'd1 << 32) / longint'(2 * n + 1) + ((s2 * t) >> 32);
        end
        return (s * t) >> 31;
    endfunction

    function automatic longint unsigned round_half_up(input longint unsigned v, input int sh);
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic terms_t logistic_terms(input logic [MARGIN_W-1:0] raw);
        logic            neg;
        longint unsigned mag, a, e, loss, g, h, smag, curv;
        terms_t          t;
        neg  = raw[MARGIN_W-1];
        mag  = neg ? ((64'd1 << 24) - raw) : raw;
        a    = mag << (32 - FRAC);
        e    = exp_neg(a);
        loss = log_one_plus(e);
        if (neg) begin
            loss += a;
        end
        loss = round_half_up(loss, 32 - FRAC);
        if (loss > 64'd16777215) loss = 64'd16777215;
        g    = (e << 31) / ((64'd1 << 32) + e);
        h    = (64'd1 << 31) - g;
        smag = round_half_up(neg ? h : g, 31 - FRAC);
        if (smag > 64'd65536) smag = 64'd65536;
        curv = round_half_up(g * h, 62 - FRAC);
        if (curv > 64'd16384) curv = 64'd16384;
        t.loss  = loss[LOSS_W-1:0];
        t.slope = 17'(64'd0 - smag);
        t.curv  = curv[CURV_W-1:0];
        return t;
    endfunction

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
    end

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        terms_t want;
        if (i_rst_n) begin
            if (i_valid && i_o_ready) begin
                expected_terms.push_back(logistic_terms(i_margin));
            end
            if (i_o_valid && i_ready) begin
                o_checked <= o_checked + 1;
                if (expected_terms.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) begin
                        $display("ERROR: unexpected output beat loss=%0d slope=%0d curv=%0d",
                                 i_loss_value, i_slope, i_curvature);
                    end
                end else begin
                    want = expected_terms.pop_front();
                    if (want.loss !== i_loss_value || want.slope !== i_slope
                        || want.curv !== i_curvature) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $display({"ERROR: loss exp %0d got %0d, slope exp %0d got %0d,",
                                      " curv exp %0d got %0d"},
                                     want.loss, i_loss_value, $signed(want.slope), i_slope,
                                     want.curv, i_curvature);
                        end
                    end
                end
            end
        end
        // beats still owed by the core
        o_pending = expected_terms.size();
    end

endmodule

/* bench/logistic_loss_and_derivatives_core_tb.sv */
// stimulus and verdict for logistic_loss_and_derivatives_core
// depends on llad_pkg, the core and llad_checker
`timescale 1ns / 1ps
module logistic_loss_and_derivatives_core_tb;
    import llad_pkg::*;

    localparam int RANDOM_BEATS = 880;
    localparam int CUT          = 23 * 65536;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [MARGIN_W-1:0] i_margin;
    logic                       o_valid;
    logic                       i_ready;
    logic [LOSS_W-1:0]          o_loss_value;
    logic signed [SLOPE_W-1:0]  o_slope;
    logic [CURV_W-1:0]          o_curvature;
    int                         fail_count;
    int                         pending;
    int                         checked;
    int                         sent;
    logic                       stall_free;

    logistic_loss_and_derivatives_core DUT (.*);

    llad_checker scoreboard (
        .i_clk, .i_rst_n, .i_valid, .i_o_ready(o_ready), .i_margin,
        .i_o_valid(o_valid), .i_ready, .i_loss_value(o_loss_value),
        .i_slope(o_slope), .i_curvature(o_curvature),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    initial i_ready = 1'b0;
    always @(posedge i_clk) begin
        if (stall_free) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= (idle_cycles() == 0);
        end
    end

    task automatic send_margin(input logic [MARGIN_W-1:0] m, input bit gaps);
        int n;
        n = gaps ? idle_cycles() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_margin <= m;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    function automatic logic [MARGIN_W-1:0] random_margin();
        int r;
        r = $urandom_range(0, 9);
        // most margins inside the range where exp(-|z|) is nonzero
        if (r < 6) return MARGIN_W'($signed($urandom_range(0, 2 * CUT)) - CUT);
        if (r < 7) return MARGIN_W'($signed($urandom_range(0, 4096)) - 2048);
        return MARGIN_W'($urandom);
    endfunction

    initial begin
        logic [MARGIN_W-1:0] directed[$];
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_margin   = '0;
        stall_free = 1'b0;
        sent       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, zero margin, large magnitude cut, ln2 steps
        directed = '{24'sd0, 24'sd1, -24'sd1, 24'sd8388607, -24'sd8388608,
                     24'sd1507327, 24'sd1507328, -24'sd1507328, -24'sd1507329,
                     24'sd45426, -24'sd45426, 24'sd45427, 24'sd90852,
                     24'sd65536, -24'sd65536, 24'sd32768, -24'sd32768,
                     24'sd1048576, -24'sd1048576, 24'h555555, 24'hAAAAAA,
                     24'sd2, -24'sd2};
        foreach (directed[i]) send_margin(directed[i], 1'b0);

        // hold the sender until the pipe has drained
        i_valid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            stall_free <= (i >= 300 && i < 400);
            send_margin(random_margin(), !(i >= 300 && i < 400));
            if (i == 600) begin
                i_valid <= 1'b0;
                wait (pending == 0);
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        stall_free <= 1'b0;

        wait (pending == 0);
        repeat (150) @(posedge i_clk);
        $display("run covered %0d margins (directed extremes, cut edges, random) with %0d beats checked",
                 sent, checked);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // limit
    initial begin
        #4000000;
        $display("timeout with %0d beats outstanding", pending);
        $display("Verification failed");
        $finish;
    end

endmodule
